// ===== rtl/core/rbsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rbsi_pkg: shared definitions for the ray/box slab intersection block
// Default word sizes, the threshold register width and the sideband flags
// that travel alongside the divider pipeline.
// ----------------------------------------------------------------------------
package rbsi_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int THRESH_WIDTH    = 17;
	localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = THRESH_WIDTH'(1);

	localparam int AXES  = 3;
	localparam int LANES = 2 * AXES;

	typedef struct packed {
		logic [AXES-1:0]  par;
		logic [AXES-1:0]  ins;
		logic [LANES-1:0] neg;
	} side_t;

endpackage

// ===== rtl/core/rbsi_div.sv =====
// ----------------------------------------------------------------------------
// rbsi_div: pipelined restoring divider
// Computes (a << FRAC_BITS) / d on unsigned magnitudes, one quotient bit per
// register stage.
// ----------------------------------------------------------------------------
module rbsi_div
	import rbsi_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic [COORD_WIDTH:0]                 a,
	input  logic [COORD_WIDTH-1:0]               d,
	output logic [COORD_WIDTH+FRAC_BITS:0]       q
);

	localparam int CW = COORD_WIDTH;
	localparam int QW = COORD_WIDTH + 1 + FRAC_BITS;

	logic [CW-1:0] rem [QW+1];
	logic [QW-1:0] num [QW+1];
	logic [QW-1:0] quo [QW+1];
	logic [CW-1:0] den [QW+1];

	assign rem[0] = '0;
	assign num[0] = {a, {FRAC_BITS{1'b0}}};
	assign quo[0] = '0;
	assign den[0] = d;

	for (genvar i = 0; i < QW; i++) begin : g_step
		logic [CW:0] trial;
		logic [CW:0] diff;

		assign trial = {rem[i], num[i][QW-1]};
		assign diff  = trial - {1'b0, den[i]};

		always_ff @(posedge clk) begin
			// A borrow out of the top bit means the divisor did not fit.
			rem[i+1] <= diff[CW] ? trial[CW-1:0] : diff[CW-1:0];
			num[i+1] <= {num[i][QW-2:0], 1'b0};
			quo[i+1] <= {quo[i][QW-2:0], ~diff[CW]};
			den[i+1] <= den[i];
		end
	end

	assign q = quo[QW];

endmodule

// ===== rtl/core/ray_box_slab_intersection.sv =====
// ----------------------------------------------------------------------------
// ray_box_slab_intersection: ray against axis-aligned box, slab method
// Fully pipelined fixed-point test returning hit, entry and exit distances.
// ----------------------------------------------------------------------------
// Usage:
//   A word is taken at each rising edge where start is high and busy is low.
//   busy is never raised, so one ray/box word may enter every cycle.
//   Each word gives one result, shown for a single cycle with done high;
//   results leave in the order the words entered and cannot be held off.
//   From the accepting edge a word passes the stage 1 registers, the six lane
//   dividers, which resolve one quotient bit per stage, and then the stage 2,
//   stage 3 and result registers. The default format is Q16.16.
//   Throughput is one word per cycle.
//   The parallel threshold is written through cfg_valid/cfg_data; cfg_ready
//   is always high. Write it only while no word is in flight.
//   Reset clears the valid bits of the pipeline and sets the threshold to 1.
// ----------------------------------------------------------------------------
module ray_box_slab_intersection
	import rbsi_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [THRESH_WIDTH-1:0]       cfg_data,
	input  logic signed [COORD_WIDTH-1:0] box_min_x,
	input  logic signed [COORD_WIDTH-1:0] box_min_y,
	input  logic signed [COORD_WIDTH-1:0] box_min_z,
	input  logic signed [COORD_WIDTH-1:0] box_max_x,
	input  logic signed [COORD_WIDTH-1:0] box_max_y,
	input  logic signed [COORD_WIDTH-1:0] box_max_z,
	input  logic signed [COORD_WIDTH-1:0] ray_origin_x,
	input  logic signed [COORD_WIDTH-1:0] ray_origin_y,
	input  logic signed [COORD_WIDTH-1:0] ray_origin_z,
	input  logic signed [COORD_WIDTH-1:0] ray_dir_x,
	input  logic signed [COORD_WIDTH-1:0] ray_dir_y,
	input  logic signed [COORD_WIDTH-1:0] ray_dir_z,
	output logic                          done,
	output logic                          hit,
	output logic signed [COORD_WIDTH-1:0] t_enter,
	output logic signed [COORD_WIDTH-1:0] t_exit
);

	localparam int CW      = COORD_WIDTH;
	localparam int QW      = COORD_WIDTH + 1 + FRAC_BITS;
	localparam int LATENCY = QW + 4;
	localparam logic signed [CW-1:0] T_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] T_MIN = {1'b1, {(CW-1){1'b0}}};

	logic [THRESH_WIDTH-1:0] thresh_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thresh_q <= cfg_data;
		end
	end

	// Stage 1: slab numerators, magnitudes and parallel tests.
	logic signed [CW-1:0] lo  [AXES];
	logic signed [CW-1:0] hi  [AXES];
	logic signed [CW-1:0] org [AXES];
	logic signed [CW-1:0] dir [AXES];

	assign lo  = '{box_min_x, box_min_y, box_min_z};
	assign hi  = '{box_max_x, box_max_y, box_max_z};
	assign org = '{ray_origin_x, ray_origin_y, ray_origin_z};
	assign dir = '{ray_dir_x, ray_dir_y, ray_dir_z};

	logic [CW:0]   amag_s1 [LANES];
	logic [CW-1:0] dmag_s1 [LANES];
	side_t         side_s1;
	logic          vld_s1;
	logic          par_c [AXES];
	logic          ins_c [AXES];
	logic          neg_c [LANES];

	for (genvar ax = 0; ax < AXES; ax++) begin : g_axis
		logic signed [CW:0] n_lo, n_hi;
		logic [CW-1:0]      ad;

		assign n_lo = {lo[ax][CW-1], lo[ax]} - {org[ax][CW-1], org[ax]};
		assign n_hi = {hi[ax][CW-1], hi[ax]} - {org[ax][CW-1], org[ax]};
		assign ad   = dir[ax][CW-1] ? CW'(-dir[ax]) : CW'(dir[ax]);
		assign par_c[ax] = (ad == '0) ||
			({{THRESH_WIDTH{1'b0}}, ad} < {{CW{1'b0}}, thresh_q});
		assign ins_c[ax] = !(org[ax] < lo[ax] || org[ax] > hi[ax]);
		assign neg_c[2*ax]   = n_lo[CW] ^ dir[ax][CW-1];
		assign neg_c[2*ax+1] = n_hi[CW] ^ dir[ax][CW-1];

		always_ff @(posedge clk) begin
			amag_s1[2*ax]     <= n_lo[CW] ? (CW+1)'(-n_lo) : (CW+1)'(n_lo);
			amag_s1[2*ax+1]   <= n_hi[CW] ? (CW+1)'(-n_hi) : (CW+1)'(n_hi);
			dmag_s1[2*ax]     <= ad;
			dmag_s1[2*ax+1]   <= ad;
		end
	end

	always_ff @(posedge clk) begin
		for (int ax = 0; ax < AXES; ax++) begin
			side_s1.par[ax] <= par_c[ax];
			side_s1.ins[ax] <= ins_c[ax];
		end
		for (int ln = 0; ln < LANES; ln++) begin
			side_s1.neg[ln] <= neg_c[ln];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	// Divider lanes, with flags and valid bits delayed to match.
	logic [QW-1:0] quo [LANES];

	for (genvar ln = 0; ln < LANES; ln++) begin : g_lane
		rbsi_div #(
			.COORD_WIDTH (COORD_WIDTH),
			.FRAC_BITS   (FRAC_BITS)
		) u_div (
			.clk (clk),
			.a   (amag_s1[ln]),
			.d   (dmag_s1[ln]),
			.q   (quo[ln])
		);
	end

	side_t side_line_q [QW];
	logic  [QW-1:0] vld_line_q;

	always_ff @(posedge clk) begin
		side_line_q[0] <= side_s1;
		for (int i = 1; i < QW; i++) begin
			side_line_q[i] <= side_line_q[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_line_q <= '0;
		end else begin
			vld_line_q <= {vld_line_q[QW-2:0], vld_s1};
		end
	end

	side_t side_dv;
	logic  vld_dv;

	assign side_dv = side_line_q[QW-1];
	assign vld_dv  = vld_line_q[QW-1];

	// Stage 2: saturate quotients, order each slab, mask parallel axes.
	logic signed [CW-1:0] t_sat [LANES];

	for (genvar ln = 0; ln < LANES; ln++) begin : g_sat
		logic big;

		assign big = |quo[ln][QW-1:CW-1];
		assign t_sat[ln] = side_dv.neg[ln] ? (big ? T_MIN : CW'(-quo[ln][CW-1:0]))
			: (big ? T_MAX : quo[ln][CW-1:0]);
	end

	logic signed [CW-1:0] near_s2 [AXES];
	logic signed [CW-1:0] far_s2  [AXES];
	logic                 ins_s2;
	logic                 vld_s2;

	always_ff @(posedge clk) begin
		for (int ax = 0; ax < AXES; ax++) begin
			if (side_dv.par[ax]) begin
				near_s2[ax] <= T_MIN;
				far_s2[ax]  <= T_MAX;
			end else if (t_sat[2*ax] > t_sat[2*ax+1]) begin
				near_s2[ax] <= t_sat[2*ax+1];
				far_s2[ax]  <= t_sat[2*ax];
			end else begin
				near_s2[ax] <= t_sat[2*ax];
				far_s2[ax]  <= t_sat[2*ax+1];
			end
		end
		// A parallel axis whose origin lies outside its slab misses outright.
		ins_s2 <= &(side_dv.ins | ~side_dv.par);
	end

	// Stage 3: narrow the interval over the three axes.
	logic signed [CW-1:0] tmin_s3, tmax_s3;
	logic signed [CW-1:0] nmax01, fmin01;
	logic                 ins_s3;
	logic                 vld_s3;

	assign nmax01 = (near_s2[0] > near_s2[1]) ? near_s2[0] : near_s2[1];
	assign fmin01 = (far_s2[0] < far_s2[1]) ? far_s2[0] : far_s2[1];

	always_ff @(posedge clk) begin
		tmin_s3 <= (nmax01 > near_s2[2]) ? nmax01 : near_s2[2];
		tmax_s3 <= (fmin01 < far_s2[2]) ? fmin01 : far_s2[2];
		ins_s3  <= ins_s2;
	end

	// Stage 4: result register.
	logic hit_c;

	assign hit_c = ins_s3 && (tmin_s3 <= tmax_s3);

	always_ff @(posedge clk) begin
		hit     <= hit_c;
		t_enter <= hit_c ? tmin_s3 : T_MAX;
		t_exit  <= hit_c ? tmax_s3 : T_MAX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s2 <= vld_dv;
			vld_s3 <= vld_s2;
			done   <= vld_s3;
		end
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("result did not appear after the pipeline latency");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result appeared without a matching accepted word");

	a_hit_order: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit |-> t_enter <= t_exit)
		else $error("hit reported with entry beyond exit");

	a_miss_value: assert property (@(posedge clk) disable iff (!arst_n)
		done && !hit |-> t_enter == T_MAX && t_exit == T_MAX)
		else $error("miss reported with distances other than the maximum");

endmodule
